@@ hw/rtl/assert_macros.svh @@
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define XMD_ASSERT_IMPL(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");

// next-cycle implication
`define XMD_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");

`endif

@@ hw/rtl/xmd_pkg.sv @@
// types and constants of the multiply/divide unit
package xmd_pkg;

   localparam logic [2:0] ACT_MUL        = 3'd0;
   localparam logic [2:0] ACT_IMUL       = 3'd1;
   localparam logic [2:0] ACT_DIV        = 3'd2;
   localparam logic [2:0] ACT_IDIV       = 3'd3;
   localparam logic [2:0] ACT_IMUL_TRUNC = 3'd4;

   localparam int DIV_STEPS = 32;

   typedef enum logic [2:0] {
      KIND_NONE,
      KIND_MUL,
      KIND_IMUL,
      KIND_DIV,
      KIND_IDIV
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic        err;
      logic        dneg;
      logic        qneg;
      logic [31:0] r;
      logic [31:0] w;
      logic [31:0] d;
   } op_type;

endpackage

@@ hw/rtl/xmd_if.sv @@
// item channel interfaces of the multiply/divide unit
interface xmd_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  action;
   logic [31:0] acc_low;
   logic [31:0] acc_high;
   logic [31:0] source_operand;
   modport source (output valid, action, acc_low, acc_high, source_operand, input ready);
   modport sink (input valid, action, acc_low, acc_high, source_operand, output ready);
endinterface

interface xmd_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] result_low;
   logic [31:0] result_high;
   logic        carry_overflow;
   logic        divide_error;
   modport source (output valid, result_low, result_high, carry_overflow, divide_error,
                   input ready);
   modport sink (input valid, result_low, result_high, carry_overflow, divide_error,
                 output ready);
endinterface

@@ hw/rtl/x86_mul_div_32_unit.sv @@
// x86 32-bit mul/imul/div/idiv execution unit, top level
// registers from item accept to result valid: front, queue, multiply stage,
//   32 quotient-bit stages, output register
// throughput: one item per cycle; the back pipeline stalls as a whole when rsp is held
// reset: synchronous, clears all valid bits and queue pointers; payload is not reset
module x86_mul_div_32_unit (
   input  logic      clock,
   input  logic      reset,
   xmd_req_if.sink   req,
   xmd_rsp_if.source rsp
);
   logic            f_valid, f_ready;
   xmd_pkg::op_type f_op;
   logic            q_valid, q_pop;
   xmd_pkg::op_type q_op;

   xmd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .out_valid (f_valid),
      .out_ready (f_ready),
      .out_op    (f_op)
   );

   xmd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .in_op     (f_op),
      .out_valid (q_valid),
      .out_ready (q_pop),
      .out_op    (q_op)
   );

   xmd_back u_back (
      .clock    (clock),
      .reset    (reset),
      .in_valid (q_valid),
      .in_pop   (q_pop),
      .in_op    (q_op),
      .rsp      (rsp)
   );
endmodule

@@ hw/rtl/xmd_front.sv @@
// front stage: accepts items, decodes action, forms operand magnitudes and error checks
module xmd_front (
   input  logic              clock,
   input  logic              reset,
   xmd_req_if.sink           req,
   output logic              out_valid,
   input  logic              out_ready,
   output xmd_pkg::op_type   out_op
);
   logic            v_ff, v_in;
   xmd_pkg::op_type op_ff, op_in;
   logic [63:0]     dvd;
   logic [63:0]     dmag;
   logic [31:0]     smag;

   assign req.ready = !v_ff || out_ready;
   assign out_valid = v_ff;
   assign out_op    = op_ff;

   always_comb begin
      dvd  = {req.acc_high, req.acc_low};
      dmag = req.acc_high[31] ? (~dvd + 64'd1) : dvd;
      smag = req.source_operand[31] ? (~req.source_operand + 32'd1) : req.source_operand;
      op_in      = '0;
      op_in.kind = xmd_pkg::KIND_NONE;
      op_in.d    = req.source_operand;
      unique case (req.action) inside
         xmd_pkg::ACT_MUL: begin
            op_in.kind = xmd_pkg::KIND_MUL;
            op_in.r    = req.acc_low;
         end
         xmd_pkg::ACT_IMUL, xmd_pkg::ACT_IMUL_TRUNC: begin
            op_in.kind = xmd_pkg::KIND_IMUL;
            op_in.r    = req.acc_low;
         end
         xmd_pkg::ACT_DIV: begin
            op_in.kind = xmd_pkg::KIND_DIV;
            op_in.err  = (req.source_operand == 32'd0) ||
                         (req.acc_high >= req.source_operand);
            op_in.r    = op_in.err ? 32'd0 : req.acc_high;
            op_in.w    = req.acc_low;
         end
         xmd_pkg::ACT_IDIV: begin
            op_in.kind = xmd_pkg::KIND_IDIV;
            op_in.err  = (req.source_operand == 32'd0) || (dmag[63:32] >= smag);
            op_in.dneg = req.acc_high[31];
            op_in.qneg = req.acc_high[31] ^ req.source_operand[31];
            op_in.r    = op_in.err ? 32'd0 : dmag[63:32];
            op_in.w    = dmag[31:0];
            op_in.d    = smag;
         end
         default: begin
            op_in.kind = xmd_pkg::KIND_NONE;
         end
      endcase
      v_in = v_ff && !out_ready;
      if (req.valid && req.ready) begin
         v_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else begin
         v_ff <= v_in;
      end
      if (req.valid && req.ready) begin
         op_ff <= op_in;
      end
   end
endmodule

@@ hw/rtl/xmd_queue.sv @@
// two-entry queue between front and back
module xmd_queue (
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   output logic            in_ready,
   input  xmd_pkg::op_type in_op,
   output logic            out_valid,
   input  logic            out_ready,
   output xmd_pkg::op_type out_op
);
   `include "assert_macros.svh"

   xmd_pkg::op_type mem_ff [2];
   logic            wr_ff, wr_in;
   logic            rd_ff, rd_in;
   logic [1:0]      cnt_ff, cnt_in;
   logic            push, pop;

   assign in_ready  = cnt_ff != 2'd2;
   assign out_valid = cnt_ff != 2'd0;
   assign out_op    = mem_ff[rd_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_ready && out_valid;

   always_comb begin
      wr_in  = push ? !wr_ff : wr_ff;
      rd_in  = pop ? !rd_ff : rd_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         mem_ff[wr_ff] <= in_op;
      end
   end

   `XMD_ASSERT_IMPL(a_cnt_range, clock, reset, 1'b1, (cnt_ff != 2'd3))
endmodule

@@ hw/rtl/xmd_back.sv @@
// back pipeline: multiply stage, one quotient bit per stage, result fix-up
module xmd_back (
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   output logic            in_pop,
   input  xmd_pkg::op_type in_op,
   xmd_rsp_if.source       rsp
);
   `include "assert_macros.svh"

   localparam int N = xmd_pkg::DIV_STEPS;

   logic            adv;
   logic            v_ff [N+1];
   xmd_pkg::op_type st_ff [N+1];
   xmd_pkg::op_type m_in;
   logic            se;
   logic signed [65:0] prod;

   logic        out_v_ff;
   logic [31:0] lo_ff, lo_in;
   logic [31:0] hi_ff, hi_in;
   logic        cf_ff, cf_in;
   logic        de_ff, de_in;
   xmd_pkg::op_type fin;
   logic        ovf;

   assign adv    = !out_v_ff || rsp.ready;
   assign in_pop = adv;

   always_comb begin
      se   = in_op.kind == xmd_pkg::KIND_IMUL;
      prod = $signed({se & in_op.r[31], in_op.r}) * $signed({se & in_op.d[31], in_op.d});
      m_in = in_op;
      if (in_op.kind == xmd_pkg::KIND_MUL || in_op.kind == xmd_pkg::KIND_IMUL) begin
         m_in.r = prod[63:32];
         m_in.w = prod[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (adv) begin
         v_ff[0] <= in_valid;
      end
      if (adv) begin
         st_ff[0] <= m_in;
      end
   end

   for (genvar g = 0; g < N; g++) begin : g_step
      logic [32:0]     t;
      logic            ge;
      logic [32:0]     diff;
      xmd_pkg::op_type nx;
      always_comb begin
         t    = {st_ff[g].r, st_ff[g].w[31]};
         ge   = t >= {1'b0, st_ff[g].d};
         diff = t - {1'b0, st_ff[g].d};
         nx   = st_ff[g];
         if (st_ff[g].kind == xmd_pkg::KIND_DIV || st_ff[g].kind == xmd_pkg::KIND_IDIV) begin
            nx.r = ge ? diff[31:0] : t[31:0];
            nx.w = {st_ff[g].w[30:0], ge};
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[g+1] <= 1'b0;
         end else if (adv) begin
            v_ff[g+1] <= v_ff[g];
         end
         if (adv) begin
            st_ff[g+1] <= nx;
         end
      end
   end

   always_comb begin
      fin   = st_ff[N];
      lo_in = 32'd0;
      hi_in = 32'd0;
      cf_in = 1'b0;
      de_in = 1'b0;
      ovf   = fin.qneg ? (fin.w > 32'h8000_0000) : fin.w[31];
      case (fin.kind)
         xmd_pkg::KIND_MUL: begin
            lo_in = fin.w;
            hi_in = fin.r;
            cf_in = fin.r != 32'd0;
         end
         xmd_pkg::KIND_IMUL: begin
            lo_in = fin.w;
            hi_in = fin.r;
            cf_in = fin.r != {32{fin.w[31]}};
         end
         xmd_pkg::KIND_DIV: begin
            de_in = fin.err;
            lo_in = fin.err ? 32'd0 : fin.w;
            hi_in = fin.err ? 32'd0 : fin.r;
         end
         xmd_pkg::KIND_IDIV: begin
            de_in = fin.err || ovf;
            if (!de_in) begin
               lo_in = fin.qneg ? (~fin.w + 32'd1) : fin.w;
               hi_in = fin.dneg ? (~fin.r + 32'd1) : fin.r;
            end
         end
         default: begin
            lo_in = 32'd0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (adv) begin
         out_v_ff <= v_ff[N];
      end
      if (adv) begin
         lo_ff <= lo_in;
         hi_ff <= hi_in;
         cf_ff <= cf_in;
         de_ff <= de_in;
      end
   end

   assign rsp.valid          = out_v_ff;
   assign rsp.result_low     = lo_ff;
   assign rsp.result_high    = hi_ff;
   assign rsp.carry_overflow = cf_ff;
   assign rsp.divide_error   = de_ff;

   `XMD_ASSERT_IMPL(a_de_zero, clock, reset, (out_v_ff && de_ff),
      (lo_ff == 32'd0 && hi_ff == 32'd0 && !cf_ff))
   `XMD_ASSERT_NEXT(a_last_hold, clock, reset, (v_ff[N] && !adv), v_ff[N])
endmodule
